// ===== design/urbc_pkg.sv =====
// ---------------------------------------------------------------------------
// urbc_pkg
// Shared types and constants of the ultrasonic range blink controller.
// ---------------------------------------------------------------------------
package urbc_pkg;

    // register index of the configuration port
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 18;

    localparam logic [CFG_IDX_BITS-1:0] REG_NEAR_LIMIT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MID_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FAR_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_NEAR_HALF  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MID_HALF   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_FAR_HALF   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_PULSE      = 3'd6;

    // reset values of the registers
    localparam logic [15:0] NEAR_LIMIT_RST = 16'd300;
    localparam logic [15:0] MID_LIMIT_RST  = 16'd500;
    localparam logic [15:0] FAR_LIMIT_RST  = 16'd700;
    localparam logic [17:0] NEAR_HALF_RST  = 18'd12500;
    localparam logic [17:0] MID_HALF_RST   = 18'd25000;
    localparam logic [17:0] FAR_HALF_RST   = 18'd250000;
    localparam logic [7:0]  PULSE_RST      = 8'd3;

    // number of blinks per measurement below the far limit
    localparam logic [2:0] BLINK_COUNT = 3'd5;

    // distance = ticks * 4 / 2 * 340 / 1000 = floor(ticks * 17 / 25)
    localparam int DIST_NUM = 17;
    localparam int DIST_DEN = 25;
    localparam int REM_BITS = $clog2(DIST_DEN);

    typedef enum logic [2:0] {
        PH_TRIG_LOW  = 3'd0,
        PH_TRIG_HIGH = 3'd1,
        PH_WAIT_RISE = 3'd2,
        PH_COUNT     = 3'd3,
        PH_BLINK_ON  = 3'd4,
        PH_BLINK_OFF = 3'd5
    } phase_t;

    typedef struct packed {
        logic [15:0] near_limit_mm;
        logic [15:0] mid_limit_mm;
        logic [15:0] far_limit_mm;
        logic [17:0] near_half_period_ticks;
        logic [17:0] mid_half_period_ticks;
        logic [17:0] far_half_period_ticks;
        logic [7:0]  pulse_ticks;
    } cfg_t;

    typedef struct packed {
        logic        trigger_level;
        logic        led_on;
        logic [15:0] distance_mm;
        logic        distance_valid;
    } result_t;

endpackage

// ===== design/urbc_seq.sv =====
// ---------------------------------------------------------------------------
// urbc_seq
// Measurement and blink sequencer: one step per accepted tick.
// ---------------------------------------------------------------------------
module urbc_seq
    import urbc_pkg::*;
#(
    parameter int ECHO_COUNT_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  logic    echo_level,
    input  cfg_t    cfg,
    output result_t res
);

    localparam logic [ECHO_COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [REM_BITS:0] NUM_W = (REM_BITS+1)'(DIST_NUM);
    localparam logic [REM_BITS:0] DEN_W = (REM_BITS+1)'(DIST_DEN);

    phase_t                     phase_reg, phase_next;
    logic [17:0]                phase_ticks_reg, phase_ticks_next;
    logic [ECHO_COUNT_BITS-1:0] echo_ticks_reg, echo_ticks_next;
    logic [ECHO_COUNT_BITS-1:0] quot_reg, quot_next;
    logic [REM_BITS-1:0]        rem_reg, rem_next;
    logic [2:0]                 blinks_left_reg, blinks_left_next;
    logic [17:0]                half_period_reg, half_period_next;
    logic                       led_level_reg, led_level_next;
    logic [15:0]                last_distance_reg, last_distance_next;

    logic [17:0]   ticks_inc;
    logic          pulse_done;
    logic          half_done;
    logic [REM_BITS:0] rem_sum;
    logic [31:0]   quot_ext;
    logic [15:0]   dist_sat;
    logic [2:0]    blinks_dec;
    logic          trig;
    logic          valid;

    // phase timer end conditions, a zero length acts as one
    assign ticks_inc  = phase_ticks_reg + 18'd1;
    assign pulse_done = (ticks_inc >= 18'(cfg.pulse_ticks)) || (ticks_inc == 18'd0);
    assign half_done  = (ticks_inc >= half_period_reg) || (ticks_inc == 18'd0);

    // running quotient and remainder of ticks * 17 / 25
    assign rem_sum  = {1'b0, rem_reg} + NUM_W;
    assign quot_ext = 32'(quot_reg);
    assign dist_sat = (quot_ext > 32'h0000_FFFF) ? 16'hFFFF : quot_ext[15:0];

    assign blinks_dec = (blinks_left_reg == 3'd0) ? 3'd0 : blinks_left_reg - 3'd1;

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        phase_ticks_next   = phase_ticks_reg;
        echo_ticks_next    = echo_ticks_reg;
        quot_next          = quot_reg;
        rem_next           = rem_reg;
        blinks_left_next   = blinks_left_reg;
        half_period_next   = half_period_reg;
        led_level_next     = led_level_reg;
        last_distance_next = last_distance_reg;
        trig               = 1'b0;
        valid              = 1'b0;
        unique case (phase_reg)
            PH_TRIG_HIGH:
            begin
                if (pulse_done)
                begin
                    phase_next       = PH_WAIT_RISE;
                    phase_ticks_next = 18'd0;
                end
                else
                begin
                    phase_ticks_next = ticks_inc;
                    trig             = 1'b1;
                end
            end
            PH_WAIT_RISE:
            begin
                if (echo_level)
                begin
                    echo_ticks_next  = ECHO_COUNT_BITS'(1);
                    quot_next        = '0;
                    rem_next         = REM_BITS'(DIST_NUM);
                    phase_next       = PH_COUNT;
                    phase_ticks_next = 18'd0;
                end
            end
            PH_COUNT:
            begin
                if (echo_level)
                begin
                    if (echo_ticks_reg < COUNT_MAX)
                    begin
                        echo_ticks_next = echo_ticks_reg + ECHO_COUNT_BITS'(1);
                        if (rem_sum >= DEN_W)
                        begin
                            rem_next  = REM_BITS'(rem_sum - DEN_W);
                            quot_next = quot_reg + ECHO_COUNT_BITS'(1);
                        end
                        else
                        begin
                            rem_next = rem_sum[REM_BITS-1:0];
                        end
                    end
                end
                else
                begin
                    last_distance_next = dist_sat;
                    valid              = 1'b1;
                    phase_ticks_next   = 18'd0;
                    priority if (dist_sat < cfg.near_limit_mm)
                        half_period_next = cfg.near_half_period_ticks;
                    else if (dist_sat < cfg.mid_limit_mm)
                        half_period_next = cfg.mid_half_period_ticks;
                    else if (dist_sat < cfg.far_limit_mm)
                        half_period_next = cfg.far_half_period_ticks;
                    else
                        half_period_next = 18'd0;
                    if (dist_sat < cfg.far_limit_mm)
                    begin
                        blinks_left_next = BLINK_COUNT;
                        led_level_next   = 1'b1;
                        phase_next       = PH_BLINK_ON;
                    end
                    else
                    begin
                        led_level_next = 1'b0;
                        phase_next     = PH_TRIG_LOW;
                    end
                end
            end
            PH_BLINK_ON:
            begin
                if (half_done)
                begin
                    led_level_next   = 1'b0;
                    phase_next       = PH_BLINK_OFF;
                    phase_ticks_next = 18'd0;
                end
                else
                begin
                    phase_ticks_next = ticks_inc;
                end
            end
            PH_BLINK_OFF:
            begin
                if (half_done)
                begin
                    blinks_left_next = blinks_dec;
                    phase_ticks_next = 18'd0;
                    if (blinks_dec == 3'd0)
                    begin
                        phase_next = PH_TRIG_LOW;
                    end
                    else
                    begin
                        led_level_next = 1'b1;
                        phase_next     = PH_BLINK_ON;
                    end
                end
                else
                begin
                    phase_ticks_next = ticks_inc;
                end
            end
            default:
            begin
                // trigger low phase, also taken by unused codes
                phase_next = PH_TRIG_LOW;
                if (pulse_done)
                begin
                    phase_next       = PH_TRIG_HIGH;
                    phase_ticks_next = 18'd0;
                    trig             = 1'b1;
                end
                else
                begin
                    phase_ticks_next = ticks_inc;
                end
            end
        endcase
    end

    // result of this tick, levels after the update
    always_comb
    begin
        res.trigger_level  = trig;
        res.led_on         = led_level_next;
        res.distance_mm    = last_distance_next;
        res.distance_valid = valid;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_TRIG_LOW;
            phase_ticks_reg   <= '0;
            echo_ticks_reg    <= '0;
            quot_reg          <= '0;
            rem_reg           <= '0;
            blinks_left_reg   <= '0;
            half_period_reg   <= '0;
            led_level_reg     <= 1'b0;
            last_distance_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            phase_ticks_reg   <= phase_ticks_next;
            echo_ticks_reg    <= echo_ticks_next;
            quot_reg          <= quot_next;
            rem_reg           <= rem_next;
            blinks_left_reg   <= blinks_left_next;
            half_period_reg   <= half_period_next;
            led_level_reg     <= led_level_next;
            last_distance_reg <= last_distance_next;
        end
    end

    // remainder of the running division stays below the divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rem_reg) < DIST_DEN)
        else $error("distance remainder out of range");

    // a new distance only comes out of the counting phase on a low echo
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.distance_valid |-> phase_reg == PH_COUNT && !echo_level)
        else $error("distance flagged outside count phase");

    // a blink on phase always has at least one blink left
    a_blinks_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BLINK_ON |-> blinks_left_reg != 3'd0)
        else $error("blink on phase with no blinks left");

    // the distance changes only on a tick that flags it
    a_dist_hold: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !res.distance_valid |-> res.distance_mm == last_distance_reg)
        else $error("distance changed without valid flag");

endmodule

// ===== design/ultrasonic_range_blink_controller_unit.sv =====
// ---------------------------------------------------------------------------
// ultrasonic_range_blink_controller_unit
// Ultrasonic rangefinder sequencer with distance coded LED blinking.
// ---------------------------------------------------------------------------
// Usage:
//  - s_* carries one word per 4 us tick; s_tdata[0] is the sampled echo pin.
//  - m_* returns one word per tick: trigger level, LED level and the last
//    distance in mm; m_tuser[0] is high on the tick a new distance is made.
//  - cfg_we/cfg_index/cfg_wdata write limits, half periods and pulse length;
//    write only while no tick is in flight. Unknown indexes are ignored.
// Throughput:
//  - one tick per cycle unless the output stalls; a tick's result is registered
//    in the cycle after it is taken. The tick's whole step (phase timer compare,
//    running distance quotient, limit compares) is one combinational pass.
// Stalls:
//  - while m_tready is low and a word is held, s_tready drops; no word is lost
//    and the sequencer does not advance.
// Reset:
//  - rst_n clears the sequencer to the trigger low phase with LED off and
//    distance zero, loads the default registers and empties the output.
// ---------------------------------------------------------------------------
module ultrasonic_range_blink_controller_unit
    import urbc_pkg::*;
#(
    parameter int ECHO_COUNT_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // tick input
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [0] echo_level, [7:1] zero
    // result output
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [23:0]              m_tdata,   // [0] trigger_level, [1] led_on,
                                                // [17:2] distance_mm, [23:18] zero
    output logic [0:0]               m_tuser,   // [0] distance_valid
    // configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    cfg_t    cfg_reg;
    result_t step_res;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    // take a tick whenever the output slot is free or being emptied
    assign s_tready = !out_valid_reg || m_tready;
    assign advance  = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_limit_mm          <= NEAR_LIMIT_RST;
            cfg_reg.mid_limit_mm           <= MID_LIMIT_RST;
            cfg_reg.far_limit_mm           <= FAR_LIMIT_RST;
            cfg_reg.near_half_period_ticks <= NEAR_HALF_RST;
            cfg_reg.mid_half_period_ticks  <= MID_HALF_RST;
            cfg_reg.far_half_period_ticks  <= FAR_HALF_RST;
            cfg_reg.pulse_ticks            <= PULSE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NEAR_LIMIT: cfg_reg.near_limit_mm          <= cfg_wdata[15:0];
                REG_MID_LIMIT:  cfg_reg.mid_limit_mm           <= cfg_wdata[15:0];
                REG_FAR_LIMIT:  cfg_reg.far_limit_mm           <= cfg_wdata[15:0];
                REG_NEAR_HALF:  cfg_reg.near_half_period_ticks <= cfg_wdata;
                REG_MID_HALF:   cfg_reg.mid_half_period_ticks  <= cfg_wdata;
                REG_FAR_HALF:   cfg_reg.far_half_period_ticks  <= cfg_wdata;
                REG_PULSE:      cfg_reg.pulse_ticks            <= cfg_wdata[7:0];
                default:        ;
            endcase
        end
    end

    // sequencer
    urbc_seq #(
        .ECHO_COUNT_BITS(ECHO_COUNT_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .echo_level (s_tdata[0]),
        .cfg        (cfg_reg),
        .res        (step_res)
    );

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {6'd0, out_reg.distance_mm, out_reg.led_on, out_reg.trigger_level};
    assign m_tuser[0] = out_reg.distance_valid;

endmodule
